[sv/hbwa_pkg.sv]
// Shared types, constants and helpers of the histogram engine with autoscale.
// No dependencies; imported by every module of the block.
package hbwa_pkg;

    localparam int COUNT_W    = 32;
    localparam int DVD_W      = 32;
    localparam int DVS_W      = 31;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int BINS_W     = 7;
    localparam int HEIGHT_W   = 10;
    localparam int SHIFT_W    = 6;
    localparam int INDEX_W    = 6;
    localparam int SUM_W      = 64;

    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 6'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOT_HEIGHT = 2'd2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [DVS_W-1:0]    RST_BIN_WIDTH   = 31'd1000;
    localparam logic [BINS_W-1:0]   RST_BINS_IN_USE = 7'd32;
    localparam logic [HEIGHT_W-1:0] RST_PLOT_HEIGHT = 10'd50;

    typedef logic [COUNT_W-1:0] count_t;

    function automatic count_t sat_inc(input count_t v);
        sat_inc = (v == '1) ? v : v + count_t'(1);
    endfunction

endpackage

[sv/histogram_bin_with_autoscale_top.sv]
// Histogram engine with power-of-two autoscale: top level.
// Uses hbwa_pkg, hbwa_div and hbwa_bin_mem.
//
// One request at a time. An add-sample request runs the bit-serial division of
// the sample by the bin width, then a read and a write-back of the bin store; a
// negative sample skips the division. A report request makes a max pass, a sum
// pass and a result pass over the bin store's one read port, a one-step-per-cycle
// search for the chosen shift (0..32), and the mean division on the shared
// divider; the result pass also waits on any output stall.
// The last result may wait in the output register while the next request is taken.
module histogram_bin_with_autoscale_top #(
    parameter int MAX_BINS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [hbwa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbwa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic signed [31:0]                sample_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [hbwa_pkg::INDEX_W-1:0]      bin_index,
    output logic [hbwa_pkg::COUNT_W-1:0]      bin_count,
    output logic [hbwa_pkg::HEIGHT_W-1:0]     bar_height,
    output logic [hbwa_pkg::SHIFT_W-1:0]      scale_shift,
    output logic [hbwa_pkg::HEIGHT_W-1:0]     mean_height,
    output logic signed [hbwa_pkg::SUM_W-1:0] running_sum,
    output logic [hbwa_pkg::COUNT_W-1:0]      running_count,
    output logic                              last_bin
);
    import hbwa_pkg::*;

    localparam int AW    = $clog2(MAX_BINS);
    localparam int TOT_W = $clog2(MAX_BINS) + HEIGHT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_WB,
        ST_MAX_RD,
        ST_MAX_USE,
        ST_SHIFT,
        ST_SUM_RD,
        ST_SUM_USE,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    state_t              state_reg;
    logic [DVS_W-1:0]    bin_width_reg;
    logic [BINS_W-1:0]   bins_in_use_reg;
    logic [HEIGHT_W-1:0] plot_height_reg;
    logic [SUM_W-1:0]    sum_reg;
    count_t              count_reg;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       k_reg;
    count_t              max_reg;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [HEIGHT_W-1:0] mean_reg;

    logic                out_valid_reg;
    logic [INDEX_W-1:0]  bin_index_reg;
    count_t              bin_count_reg;
    logic [HEIGHT_W-1:0] bar_height_reg;
    logic [SHIFT_W-1:0]  scale_shift_reg;
    logic [HEIGHT_W-1:0] mean_height_reg;
    logic [SUM_W-1:0]    running_sum_reg;
    count_t              running_count_reg;
    logic                last_bin_reg;

    logic [BINS_W-1:0]   n_used;
    logic [AW-1:0]       n_m1;
    logic [DVS_W-1:0]    w_eff;
    logic                in_acc;
    logic                k_last;
    logic                out_free;

    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic                mem_wr_en;
    count_t              mem_rd_data;

    logic                div_start;
    logic [DVD_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic                div_done;
    logic [DVD_W-1:0]    div_q;

    count_t              h_cur;
    count_t              max_sh;
    logic [AW-1:0]       idx_next;

    always_comb
    begin
        if (bins_in_use_reg == '0)
        begin
            n_used = BINS_W'(1);
        end
        else if (bins_in_use_reg > BINS_W'(MAX_BINS))
        begin
            n_used = BINS_W'(MAX_BINS);
        end
        else
        begin
            n_used = bins_in_use_reg;
        end
    end

    assign n_m1     = AW'(n_used - BINS_W'(1));
    assign w_eff    = (bin_width_reg == '0) ? DVS_W'(1) : bin_width_reg;
    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign k_last   = (k_reg == n_m1);
    assign out_free = !out_valid_reg || !out_stall;

    assign mem_rd_en   = state_reg inside {ST_RD, ST_MAX_RD, ST_SUM_RD, ST_EMIT_RD};
    assign mem_rd_addr = (state_reg == ST_RD) ? idx_reg : k_reg;
    assign mem_wr_en   = (state_reg == ST_WB);

    assign div_start    = (in_acc && (opcode == OP_ADD) && !sample_value[31])
                          || (state_reg == ST_MEAN);
    assign div_dividend = (state_reg == ST_IDLE) ? DVD_W'(unsigned'(sample_value))
                                                 : DVD_W'(total_reg);
    assign div_divisor  = (state_reg == ST_IDLE) ? w_eff : DVS_W'(n_used);

    assign h_cur    = mem_rd_data >> shift_reg;
    assign max_sh   = max_reg >> shift_reg;
    assign idx_next = (div_q >= DVD_W'(n_used)) ? n_m1 : AW'(div_q);

    hbwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    hbwa_bin_mem #(
        .DEPTH (MAX_BINS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .wr_en   (mem_wr_en),
        .wr_addr (idx_reg),
        .wr_data (sat_inc(mem_rd_data)),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            bin_width_reg     <= RST_BIN_WIDTH;
            bins_in_use_reg   <= RST_BINS_IN_USE;
            plot_height_reg   <= RST_PLOT_HEIGHT;
            sum_reg           <= '0;
            count_reg         <= '0;
            idx_reg           <= '0;
            k_reg             <= '0;
            max_reg           <= '0;
            shift_reg         <= '0;
            total_reg         <= '0;
            mean_reg          <= '0;
            out_valid_reg     <= 1'b0;
            bin_index_reg     <= '0;
            bin_count_reg     <= '0;
            bar_height_reg    <= '0;
            scale_shift_reg   <= '0;
            mean_height_reg   <= '0;
            running_sum_reg   <= '0;
            running_count_reg <= '0;
            last_bin_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_BIN_WIDTH:   bin_width_reg   <= cfg_data;
                    CFG_BINS_IN_USE: bins_in_use_reg <= cfg_data[BINS_W-1:0];
                    CFG_PLOT_HEIGHT: plot_height_reg <= cfg_data[HEIGHT_W-1:0];
                    default:         ;
                endcase
            end

            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (opcode == OP_ADD)
                        begin
                            sum_reg   <= sum_reg + {{32{sample_value[31]}}, sample_value};
                            count_reg <= sat_inc(count_reg);
                            if (sample_value[31])
                            begin
                                idx_reg   <= '0;
                                state_reg <= ST_RD;
                            end
                            else
                            begin
                                state_reg <= ST_DIV;
                            end
                        end
                        else
                        begin
                            k_reg     <= '0;
                            max_reg   <= '0;
                            state_reg <= ST_MAX_RD;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        idx_reg   <= idx_next;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_MAX_RD:
                begin
                    state_reg <= ST_MAX_USE;
                end
                ST_MAX_USE:
                begin
                    if (mem_rd_data > max_reg)
                    begin
                        max_reg <= mem_rd_data;
                    end
                    if (k_last)
                    begin
                        shift_reg <= '0;
                        state_reg <= ST_SHIFT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= ST_MAX_RD;
                    end
                end
                ST_SHIFT:
                begin
                    if ((shift_reg < SHIFT_MAX) && (max_sh > COUNT_W'(plot_height_reg)))
                    begin
                        shift_reg <= shift_reg + SHIFT_W'(1);
                    end
                    else
                    begin
                        k_reg     <= '0;
                        total_reg <= '0;
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_SUM_RD:
                begin
                    state_reg <= ST_SUM_USE;
                end
                ST_SUM_USE:
                begin
                    total_reg <= total_reg + TOT_W'(h_cur);
                    if (k_last)
                    begin
                        state_reg <= ST_MEAN;
                    end
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_MEAN:
                begin
                    state_reg <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= div_q[HEIGHT_W-1:0];
                        k_reg     <= '0;
                        state_reg <= ST_EMIT_RD;
                    end
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_OUT;
                end
                ST_EMIT_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        bin_index_reg     <= INDEX_W'(k_reg);
                        bin_count_reg     <= mem_rd_data;
                        bar_height_reg    <= h_cur[HEIGHT_W-1:0];
                        scale_shift_reg   <= shift_reg;
                        mean_height_reg   <= mean_reg;
                        running_sum_reg   <= sum_reg;
                        running_count_reg <= count_reg;
                        last_bin_reg      <= k_last;
                        if (k_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + AW'(1);
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign bin_index     = bin_index_reg;
    assign bin_count     = bin_count_reg;
    assign bar_height    = bar_height_reg;
    assign scale_shift   = scale_shift_reg;
    assign mean_height   = mean_height_reg;
    assign running_sum   = signed'(running_sum_reg);
    assign running_count = running_count_reg;
    assign last_bin      = last_bin_reg;

`ifndef SYNTHESIS
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (scale_shift_reg <= SHIFT_MAX))
        else $error("scale shift out of range");

    a_bar_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (bar_height_reg <= plot_height_reg))
        else $error("scaled bar above plot height");

    a_mean_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (mean_height_reg <= plot_height_reg))
        else $error("mean height above plot height");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_bin_reg) |-> (bin_index_reg == INDEX_W'(n_m1)))
        else $error("last result not on last bin in use");

    a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_DIV) || (state_reg == ST_MEAN_WAIT)))
        else $error("divider finished with no one waiting");
`endif

endmodule

[sv/hbwa_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the sample binning and the mean height; uses hbwa_pkg.
module hbwa_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hbwa_pkg::DVD_W-1:0] dividend,
    input  logic [hbwa_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [hbwa_pkg::DVD_W-1:0] quotient
);
    import hbwa_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     dvs_reg;

    logic [DVS_W:0] rem_sh;
    logic           ge;

    assign rem_sh = {rem_reg, quo_reg[DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
                quo_reg <= {quo_reg[DVD_W-2:0], ge};
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/hbwa_bin_mem.sv]
// Bin count store: synchronous memory with a registered read.
// Per-entry valid bits make unwritten bins read as zero after reset; uses hbwa_pkg.
module hbwa_bin_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [hbwa_pkg::COUNT_W-1:0] wr_data,
    output logic [hbwa_pkg::COUNT_W-1:0] rd_data
);
    import hbwa_pkg::*;

    count_t             mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    count_t             rd_q_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

[tb/sv/tb_histogram_bin_with_autoscale_top.sv]
// Self-checking testbench for histogram_bin_with_autoscale_top: directed and random
// sample/report traffic checked against an in-bench histogram predictor.
// Depends on hbwa_pkg and the histogram_bin_with_autoscale_top RTL.
`timescale 1ns / 100ps

module tb_histogram_bin_with_autoscale_top;

    import hbwa_pkg::*;

    localparam int NBINS        = 32;
    localparam int SETTLE       = 48;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTED = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [INDEX_W-1:0]      index;
        logic [COUNT_W-1:0]      count;
        logic [HEIGHT_W-1:0]     height;
        logic [SHIFT_W-1:0]      shift;
        logic [HEIGHT_W-1:0]     mean;
        logic signed [SUM_W-1:0] sum;
        logic [COUNT_W-1:0]      samples;
        logic                    is_last;
    } bin_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          opcode;
    logic signed [31:0]            sample_value;
    logic                          out_valid;
    logic                          out_stall;
    logic [INDEX_W-1:0]            bin_index;
    logic [COUNT_W-1:0]            bin_count;
    logic [HEIGHT_W-1:0]           bar_height;
    logic [SHIFT_W-1:0]            scale_shift;
    logic [HEIGHT_W-1:0]           mean_height;
    logic signed [SUM_W-1:0]       running_sum;
    logic [COUNT_W-1:0]            running_count;
    logic                          last_bin;

    // histogram predictor state
    logic [COUNT_W-1:0]            bin_tally [NBINS];
    logic signed [SUM_W-1:0]       tally_sum;
    logic [COUNT_W-1:0]            tally_count;
    logic [DVS_W-1:0]              width_reg;
    logic [BINS_W-1:0]             bins_reg;
    logic [HEIGHT_W-1:0]           height_reg;

    bin_row_t                      report_rows [$];

    int unsigned                   src_idle_pct;
    int unsigned                   sink_idle_pct;
    int unsigned                   mismatches;
    int unsigned                   cycles;
    int unsigned                   n_samples;
    int unsigned                   n_reports;
    int unsigned                   n_rows;
    int unsigned                   n_writes;

    histogram_bin_with_autoscale_top #(
        .MAX_BINS (NBINS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bin_index     (bin_index),
        .bin_count     (bin_count),
        .bar_height    (bar_height),
        .scale_shift   (scale_shift),
        .mean_height   (mean_height),
        .running_sum   (running_sum),
        .running_count (running_count),
        .last_bin      (last_bin)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    function automatic int unsigned used_bins();
        if (bins_reg == '0)
            return 1;
        if (bins_reg > NBINS)
            return NBINS;
        return bins_reg;
    endfunction

    task automatic tally_sample(input logic [31:0] val);
        logic [DVS_W-1:0] w;
        logic [31:0]      q;
        int unsigned      n;
        int unsigned      idx;
        begin
            n   = used_bins();
            idx = 0;
            if (!val[31])
            begin
                w   = (width_reg == '0) ? DVS_W'(1) : width_reg;
                q   = val / {1'b0, w};
                idx = (q >= n) ? n - 1 : q;
            end
            if (bin_tally[idx] != '1)
                bin_tally[idx] = bin_tally[idx] + 1;
            tally_sum = tally_sum + {{32{val[31]}}, val};
            if (tally_count != '1)
                tally_count = tally_count + 1;
        end
    endtask

    task automatic predict_report();
        int unsigned        n;
        int unsigned        shift;
        logic [COUNT_W-1:0] maxc;
        logic [31:0]        total;
        logic [31:0]        mean;
        logic [63:0]        h;
        bin_row_t           row;
        begin
            n     = used_bins();
            maxc  = '0;
            shift = 0;
            total = '0;
            for (int k = 0; k < n; k++)
                if (bin_tally[k] > maxc)
                    maxc = bin_tally[k];
            while (shift < 32 && (64'(maxc) >> shift) > 64'(height_reg))
                shift++;
            for (int k = 0; k < n; k++)
                total = total + 32'(64'(bin_tally[k]) >> shift);
            mean = total / n;
            for (int k = 0; k < n; k++)
            begin
                h           = 64'(bin_tally[k]) >> shift;
                row.index   = INDEX_W'(k);
                row.count   = bin_tally[k];
                row.height  = h[HEIGHT_W-1:0];
                row.shift   = SHIFT_W'(shift);
                row.mean    = mean[HEIGHT_W-1:0];
                row.sum     = tally_sum;
                row.samples = tally_count;
                row.is_last = (k == n - 1);
                report_rows.push_back(row);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        bin_row_t row;
        if (rst_n && out_valid && !out_stall)
        begin
            if (report_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $error("bin result %0d arrived with none expected", bin_index);
            end
            else
            begin
                row = report_rows.pop_front();
                n_rows++;
                check_field("bin_index", row.index, bin_index);
                check_field("bin_count", row.count, bin_count);
                check_field("bar_height", row.height, bar_height);
                check_field("scale_shift", row.shift, scale_shift);
                check_field("mean_height", row.mean, mean_height);
                check_field("running_sum", row.sum, running_sum);
                check_field("running_count", row.samples, running_count);
                check_field("last_bin", row.is_last, last_bin);
            end
        end
    end

    task automatic send_req(input logic op, input logic [31:0] val);
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid     <= 1'b1;
            opcode       <= op;
            sample_value <= val;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            if (op == OP_ADD)
            begin
                tally_sample(val);
                n_samples++;
            end
            else
            begin
                predict_report();
                n_reports++;
            end
        end
    endtask

    // drop valid, wait for every outstanding bin result, then hold for settle cycles
    task automatic wait_idle(input int settle);
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (report_rows.size() != 0)
                @(posedge clk);
            repeat (settle) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            @(posedge clk);
            case (idx)
                CFG_BIN_WIDTH:   width_reg  = data[DVS_W-1:0];
                CFG_BINS_IN_USE: bins_reg   = data[BINS_W-1:0];
                CFG_PLOT_HEIGHT: height_reg = data[HEIGHT_W-1:0];
                default:         ;
            endcase
            n_writes++;
        end
    endtask

    task automatic test_empty_report();
        send_req(OP_REPORT, 32'h0);
    endtask

    task automatic test_bin_edges();
        begin
            send_req(OP_ADD, 32'd0);
            send_req(OP_ADD, 32'd999);
            send_req(OP_ADD, 32'd1000);
            send_req(OP_ADD, 32'd31999);
            send_req(OP_ADD, 32'd32000);
            send_req(OP_ADD, 32'h7FFF_FFFF);
            send_req(OP_ADD, 32'hFFFF_FFFF);
            send_req(OP_ADD, 32'h8000_0000);
            send_req(OP_REPORT, 32'hFFFF_FFFF);
        end
    endtask

    task automatic test_register_extremes();
        begin
            wait_idle(SETTLE);
            write_reg(CFG_BIN_WIDTH, '0);
            write_reg(CFG_BINS_IN_USE, 31'h7FFF_FF80);
            write_reg(CFG_PLOT_HEIGHT, '0);
            write_reg(CFG_UNUSED, 31'h7FFF_FFFF);
            send_req(OP_ADD, 32'd5);
            send_req(OP_ADD, -32'sd7);
            send_req(OP_REPORT, 32'h5555_5555);
            wait_idle(SETTLE);
            write_reg(CFG_BIN_WIDTH, 31'h7FFF_FFFF);
            write_reg(CFG_BINS_IN_USE, 31'd127);
            write_reg(CFG_PLOT_HEIGHT, 31'h7FFF_FFFF);
            send_req(OP_ADD, 32'h7FFF_FFFF);
            send_req(OP_ADD, 32'h7FFF_FFFE);
            send_req(OP_REPORT, 32'hAAAA_AAAA);
        end
    endtask

    task automatic test_shift_search();
        begin
            wait_idle(SETTLE);
            write_reg(CFG_PLOT_HEIGHT, 31'd1);
            send_req(OP_ADD, 32'd10);
            send_req(OP_ADD, 32'd20);
            send_req(OP_ADD, 32'd30);
            send_req(OP_ADD, 32'd40);
            send_req(OP_REPORT, 32'h0);
        end
    endtask

    task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct,
                               input int unsigned items, input logic [CFG_DATA_W-1:0] bw,
                               input logic [CFG_DATA_W-1:0] nb,
                               input logic [CFG_DATA_W-1:0] ph);
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        bit          first;
        logic [63:0] span;
        logic [31:0] val;
        begin
            wait_idle(SETTLE);
            write_reg(CFG_BIN_WIDTH, bw);
            write_reg(CFG_BINS_IN_USE, nb);
            write_reg(CFG_PLOT_HEIGHT, ph);
            src_idle_pct  = src_pct;
            sink_idle_pct = sink_pct;
            sent  = 0;
            first = 1'b1;
            while (sent < items)
            begin
                burst = $urandom_range(8);
                repeat (burst)
                begin
                    pick = $urandom_range(9);
                    span = 64'((width_reg == '0) ? 1 : width_reg) * (used_bins() + 1);
                    if (span > 64'h7FFF_FFFF)
                        span = 64'h7FFF_FFFF;
                    if (pick == 0)
                        val = {1'b1, 31'($urandom)};
                    else if (pick == 1)
                        val = $urandom;
                    else
                        val = $urandom_range(0, 32'(span));
                    send_req(OP_ADD, val);
                    sent++;
                end
                // hold the sender until the block has emptied at least once per phase
                if (first || $urandom_range(3) == 0)
                    wait_idle(0);
                first = 1'b0;
                send_req(OP_REPORT, $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_BIN_WIDTH;
        cfg_data      = '0;
        in_valid      = 1'b0;
        opcode        = OP_ADD;
        sample_value  = '0;
        out_stall     = 1'b0;
        src_idle_pct  = 32;
        sink_idle_pct = 46;
        mismatches    = 0;
        cycles        = 0;
        n_samples     = 0;
        n_reports     = 0;
        n_rows        = 0;
        n_writes      = 0;
        width_reg     = RST_BIN_WIDTH;
        bins_reg      = RST_BINS_IN_USE;
        height_reg    = RST_PLOT_HEIGHT;
        tally_sum     = '0;
        tally_count   = '0;
        for (int k = 0; k < NBINS; k++)
            bin_tally[k] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_report();
        test_bin_edges();
        test_register_extremes();
        test_shift_search();
        test_random(32, 46, 50, 31'd7, 31'd16, 31'd3);
        test_random(46, 32, 50, 31'd1, 31'd64, 31'd0);
        test_random(0, 0, 50, 31'd250, 31'd5, 31'd1023);

        wait_idle(SETTLE);
        $display("Covered %0d samples and %0d reports over %0d register writes;",
                 n_samples, n_reports, n_writes);
        $display("%0d bin results checked across three idle/stall mixes.", n_rows);
        if (report_rows.size() != 0)
        begin
            mismatches++;
            $error("%0d expected bin results never arrived", report_rows.size());
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/hbwa_pkg.sv
sv/hbwa_div.sv
sv/hbwa_bin_mem.sv
sv/histogram_bin_with_autoscale_top.sv
tb/sv/tb_histogram_bin_with_autoscale_top.sv
